// ----- hw/rtl/bandpass_iir_filter_order4_macros.svh -----
// ----------------------------------------------------------------------------
// bandpass_iir_filter_order4 assertion macros
// concurrent assertion wrappers clocked on clk, used by the checker file
// ----------------------------------------------------------------------------
`ifndef BANDPASS_IIR_FILTER_ORDER4_MACROS_SVH
`define BANDPASS_IIR_FILTER_ORDER4_MACROS_SVH

// checked at every rising clk edge, held off while rst is high
`define BPIIR_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// checked at every rising clk edge, reset cycles included
`define BPIIR_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

// ----- hw/rtl/bpiir_pkg.sv -----
// ----------------------------------------------------------------------------
// bpiir_pkg
// shared constants, command and status types for the band-pass iir filter
// ----------------------------------------------------------------------------
package bpiir_pkg;

  localparam int NUM_CHANNELS = 2;
  localparam int SAMPLE_BITS  = 24;

  localparam int COEF_W     = 32;
  localparam int COEF_FRAC  = 24;
  localparam int DELAY_W    = 48;
  localparam int DELAY_FRAC = 16;
  localparam int NUM_TAPS   = 4;
  localparam int TAP_W      = $clog2(NUM_TAPS);
  localparam int ROW_W      = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
  localparam int GAIN_SHIFT = COEF_FRAC - DELAY_FRAC;

  // b0 * x rounded down by GAIN_SHIFT bits
  localparam int BX_W   = SAMPLE_BITS + 24;
  // a_k * y rounded down by COEF_FRAC bits
  localparam int FA_W   = COEF_W + DELAY_W - COEF_FRAC + 1;
  localparam int WIDE_W = ((BX_W + 1 > FA_W) ? BX_W + 1 : FA_W) + 2;
  localparam int MUL_W  = COEF_W + 1;
  localparam int PROD_W = 2 * MUL_W;
  localparam int ACC_W  = COEF_W + DELAY_FRAC + 2;

  localparam int CFG_IDX_W = 3;
  localparam logic [CFG_IDX_W-1:0] REG_B0 = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_A1 = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_A2 = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_A3 = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_A4 = 3'd4;

  localparam logic signed [COEF_W-1:0] B0_RESET = 32'sd378571;
  localparam logic signed [COEF_W-1:0] A1_RESET = -32'sd58217262;
  localparam logic signed [COEF_W-1:0] A2_RESET = 32'sd76789494;
  localparam logic signed [COEF_W-1:0] A3_RESET = -32'sd45779447;
  localparam logic signed [COEF_W-1:0] A4_RESET = 32'sd10446507;

  typedef enum logic [1:0] {
    MUL_NONE,
    MUL_GAIN,
    MUL_LOW,
    MUL_HIGH
  } mul_sel_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_MUL_GAIN,
    ST_ROUND_GAIN,
    ST_SUM_Y,
    ST_LOW,
    ST_HIGH,
    ST_SUM,
    ST_UPDATE,
    ST_SUM_LAST,
    ST_UPDATE_LAST,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic             load;
    mul_sel_t         mul_sel;
    logic [TAP_W-1:0] coef_sel;
    logic             bx_load;
    logic             y_load;
    logic             acc_load;
    logic             fa_load;
    logic             upd_en;
    logic [TAP_W-1:0] upd_sel;
    logic             finish;
  } bpiir_cmd_t;

  typedef struct packed {
    logic out_full;
  } bpiir_status_t;

endpackage

// ----- hw/rtl/bpiir_ctrl.sv -----
// ----------------------------------------------------------------------------
// bpiir_ctrl
// sequencer that steps the shared multiplier through one filter update
// ----------------------------------------------------------------------------
module bpiir_ctrl
  import bpiir_pkg::*;
(
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  input  bpiir_status_t status,
  output logic          in_stall,
  output bpiir_cmd_t    cmd
);

  state_t           state;
  state_t           state_next;
  logic [TAP_W-1:0] tap;
  logic [TAP_W-1:0] tap_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      tap   <= '0;
    end else begin
      state <= state_next;
      tap   <= tap_next;
    end
  end

  always_comb begin
    state_next = state;
    tap_next   = tap;
    unique case (state)
      ST_IDLE:        if (in_valid) state_next = ST_MUL_GAIN;
      ST_MUL_GAIN:    state_next = ST_ROUND_GAIN;
      ST_ROUND_GAIN:  state_next = ST_SUM_Y;
      ST_SUM_Y: begin
        state_next = ST_LOW;
        tap_next   = '0;
      end
      ST_LOW:         state_next = ST_HIGH;
      ST_HIGH:        state_next = ST_SUM;
      ST_SUM:         state_next = ST_UPDATE;
      ST_UPDATE: begin
        tap_next   = tap + TAP_W'(1);
        state_next = (tap == TAP_W'(NUM_TAPS - 2)) ? ST_SUM_LAST : ST_SUM;
      end
      ST_SUM_LAST:    state_next = ST_UPDATE_LAST;
      ST_UPDATE_LAST: state_next = ST_DONE;
      ST_DONE:        if (!status.out_full) state_next = ST_IDLE;
      default:        state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd      = '0;
    in_stall = 1'b1;
    unique case (state)
      ST_IDLE: begin
        in_stall = rst;
        cmd.load = in_valid && !rst;
      end
      ST_MUL_GAIN:   cmd.mul_sel = MUL_GAIN;
      ST_ROUND_GAIN: cmd.bx_load = 1'b1;
      ST_SUM_Y:      cmd.y_load  = 1'b1;
      ST_LOW: begin
        cmd.mul_sel  = MUL_LOW;
        cmd.coef_sel = '0;
      end
      ST_HIGH: begin
        cmd.mul_sel  = MUL_HIGH;
        cmd.coef_sel = '0;
        cmd.acc_load = 1'b1;
      end
      // finish tap k while the low half of tap k+1 is multiplied
      ST_SUM: begin
        cmd.fa_load  = 1'b1;
        cmd.mul_sel  = MUL_LOW;
        cmd.coef_sel = tap + TAP_W'(1);
      end
      ST_UPDATE: begin
        cmd.upd_en   = 1'b1;
        cmd.upd_sel  = tap;
        cmd.acc_load = 1'b1;
        cmd.mul_sel  = MUL_HIGH;
        cmd.coef_sel = tap + TAP_W'(1);
      end
      ST_SUM_LAST:   cmd.fa_load = 1'b1;
      ST_UPDATE_LAST: begin
        cmd.upd_en  = 1'b1;
        cmd.upd_sel = tap;
      end
      ST_DONE:       cmd.finish = !status.out_full;
      default:       cmd = '0;
    endcase
  end

endmodule

// ----- hw/rtl/bpiir_datapath.sv -----
// ----------------------------------------------------------------------------
// bpiir_datapath
// coefficient registers, delay store, shared multiplier and output register
// ----------------------------------------------------------------------------
module bpiir_datapath
  import bpiir_pkg::*;
(
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_we,
  input  logic [CFG_IDX_W-1:0]          cfg_index,
  input  logic [COEF_W-1:0]             cfg_data,
  input  logic                          chan,
  input  logic signed [SAMPLE_BITS-1:0] sample_in,
  input  logic                          block_start,
  input  bpiir_cmd_t                    cmd,
  output bpiir_status_t                 status,
  input  logic                          out_stall,
  output logic                          out_valid,
  output logic                          chan_out,
  output logic signed [SAMPLE_BITS-1:0] sample_out
);

  localparam logic signed [PROD_W-1:0]  GAIN_HALF = PROD_W'(1) << (GAIN_SHIFT - 1);
  localparam logic signed [ACC_W-1:0]   COEF_HALF = ACC_W'(1) << (COEF_FRAC - 1);
  localparam logic signed [DELAY_W:0]   OUT_HALF  = (DELAY_W + 1)'(1) << (DELAY_FRAC - 1);

  function automatic logic signed [DELAY_W-1:0] sat_delay(input logic signed [WIDE_W-1:0] v);
    logic [WIDE_W-DELAY_W:0] top;
    top = v[WIDE_W-1:DELAY_W-1];
    if ((&top) || !(|top)) begin
      sat_delay = v[DELAY_W-1:0];
    end else if (v[WIDE_W-1]) begin
      sat_delay = {1'b1, {(DELAY_W - 1){1'b0}}};
    end else begin
      sat_delay = {1'b0, {(DELAY_W - 1){1'b1}}};
    end
  endfunction

  logic signed [COEF_W-1:0]      b0_gain;
  logic signed [COEF_W-1:0]      a_coef [NUM_TAPS];
  logic signed [DELAY_W-1:0]     delay_mem [NUM_CHANNELS][NUM_TAPS];
  logic signed [DELAY_W-1:0]     d_reg [NUM_TAPS];
  logic [ROW_W-1:0]              row_sel;
  logic [ROW_W-1:0]              row_idx;
  logic                          chan_reg;
  logic signed [SAMPLE_BITS-1:0] x_reg;
  logic signed [PROD_W-1:0]      prod;
  logic signed [BX_W-1:0]        bx_reg;
  logic signed [DELAY_W-1:0]     y_reg;
  logic signed [ACC_W-1:0]       acc_reg;
  logic signed [FA_W-1:0]        fa_reg;

  logic signed [MUL_W-1:0]       mul_a;
  logic signed [MUL_W-1:0]       mul_b;
  logic signed [PROD_W-1:0]      prod_full;
  logic signed [PROD_W-1:0]      gain_round;
  logic signed [PROD_W-1:0]      gain_shift;
  logic signed [WIDE_W-1:0]      y_sum;
  logic signed [ACC_W-1:0]       acc_shift;
  logic signed [PROD_W-1:0]      fa_sum;
  logic signed [PROD_W-1:0]      fa_shift;
  logic signed [WIDE_W-1:0]      bx_wide;
  logic signed [WIDE_W-1:0]      fa_wide;
  logic signed [WIDE_W-1:0]      upd_sum;
  logic signed [DELAY_W:0]       out_sum;
  logic signed [DELAY_W:0]       out_shift;
  logic signed [SAMPLE_BITS-1:0] out_sat;

  // coefficient registers
  always_ff @(posedge clk) begin
    if (rst) begin
      b0_gain   <= B0_RESET;
      a_coef[0] <= A1_RESET;
      a_coef[1] <= A2_RESET;
      a_coef[2] <= A3_RESET;
      a_coef[3] <= A4_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_B0:  b0_gain   <= $signed(cfg_data);
        REG_A1:  a_coef[0] <= $signed(cfg_data);
        REG_A2:  a_coef[1] <= $signed(cfg_data);
        REG_A3:  a_coef[2] <= $signed(cfg_data);
        REG_A4:  a_coef[3] <= $signed(cfg_data);
        default: ;
      endcase
    end
  end

  assign row_idx = (NUM_CHANNELS == 1) ? '0 : ROW_W'(chan);

  // shared multiplier, y split into a signed high word and an unsigned low half
  always_comb begin
    mul_a = {a_coef[cmd.coef_sel][COEF_W-1], a_coef[cmd.coef_sel]};
    mul_b = '0;
    case (cmd.mul_sel)
      MUL_GAIN: begin
        mul_a = {b0_gain[COEF_W-1], b0_gain};
        mul_b = {{(MUL_W - SAMPLE_BITS){x_reg[SAMPLE_BITS-1]}}, x_reg};
      end
      MUL_LOW:  mul_b = {{(MUL_W - DELAY_FRAC){1'b0}}, y_reg[DELAY_FRAC-1:0]};
      MUL_HIGH: mul_b = {{(MUL_W - DELAY_W + DELAY_FRAC){y_reg[DELAY_W-1]}},
                         y_reg[DELAY_W-1:DELAY_FRAC]};
      default:  mul_b = '0;
    endcase
  end

  assign prod_full = mul_a * mul_b;

  always_comb begin
    gain_round = prod + GAIN_HALF;
    gain_shift = gain_round >>> GAIN_SHIFT;
    y_sum      = WIDE_W'(bx_reg) + WIDE_W'(d_reg[0]);
    acc_shift  = acc_reg >>> DELAY_FRAC;
    // high product plus the rounded low product, then the last rounding shift
    fa_sum     = prod + PROD_W'(acc_shift);
    fa_shift   = fa_sum >>> GAIN_SHIFT;
    bx_wide    = WIDE_W'(bx_reg);
    fa_wide    = WIDE_W'(fa_reg);
    case (cmd.upd_sel)
      TAP_W'(0): upd_sum = WIDE_W'(d_reg[1]) - fa_wide;
      TAP_W'(1): upd_sum = WIDE_W'(d_reg[2]) - (bx_wide <<< 1) - fa_wide;
      TAP_W'(2): upd_sum = WIDE_W'(d_reg[3]) - fa_wide;
      default:   upd_sum = bx_wide - fa_wide;
    endcase
    out_sum   = (DELAY_W + 1)'(y_reg) + OUT_HALF;
    out_shift = out_sum >>> DELAY_FRAC;
    if ((&out_shift[DELAY_W:SAMPLE_BITS-1]) || !(|out_shift[DELAY_W:SAMPLE_BITS-1])) begin
      out_sat = out_shift[SAMPLE_BITS-1:0];
    end else if (out_shift[DELAY_W]) begin
      out_sat = {1'b1, {(SAMPLE_BITS - 1){1'b0}}};
    end else begin
      out_sat = {1'b0, {(SAMPLE_BITS - 1){1'b1}}};
    end
  end

  // working registers
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      chan_reg <= chan;
      x_reg    <= sample_in;
      row_sel  <= row_idx;
      for (int t = 0; t < NUM_TAPS; t++) begin
        d_reg[t] <= block_start ? '0 : delay_mem[row_idx][t];
      end
    end
    if (cmd.mul_sel != MUL_NONE) prod    <= prod_full;
    if (cmd.bx_load)             bx_reg  <= gain_shift[BX_W-1:0];
    if (cmd.y_load)              y_reg   <= sat_delay(y_sum);
    if (cmd.acc_load)            acc_reg <= $signed(prod[ACC_W-1:0]) + COEF_HALF;
    if (cmd.fa_load)             fa_reg  <= fa_shift[FA_W-1:0];
    if (cmd.upd_en)              d_reg[cmd.upd_sel] <= sat_delay(upd_sum);
  end

  // per-channel delay store
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int c = 0; c < NUM_CHANNELS; c++) begin
        for (int t = 0; t < NUM_TAPS; t++) begin
          delay_mem[c][t] <= '0;
        end
      end
    end else if (cmd.finish) begin
      for (int t = 0; t < NUM_TAPS; t++) begin
        delay_mem[row_sel][t] <= d_reg[t];
      end
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.finish) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      chan_out   <= chan_reg;
      sample_out <= out_sat;
    end
  end

  assign status.out_full = out_valid && out_stall;

endmodule

// ----- hw/rtl/bandpass_iir_filter_order4.sv -----
// ----------------------------------------------------------------------------
// bandpass_iir_filter_order4
// two-channel fourth-order butterworth band-pass iir filter, fixed point
// ----------------------------------------------------------------------------
// Filters signed samples of two independent channels through a band-pass
// section in transposed direct form II: numerator b0*(1,0,-2,0,1), denominator
// (1,a1,a2,a3,a4), all coefficients signed Q7.24 in writable registers. Each
// channel keeps four 48-bit delay terms (16 fractional bits); block_start
// clears the addressed channel's delays before its sample is filtered. The
// result is rounded to an integer and saturated to SAMPLE_BITS bits. One
// sample is processed at a time and no new one is taken until it is done:
// all nine products (gain and the high and low halves of a1..a4 times y) go
// through one shared 33x33 multiplier, with the rounding and delay updates
// overlapped with the next product. A finished result waits in the output
// register; if it has not been taken the block holds the next result in its
// last step until the register frees.
// ----------------------------------------------------------------------------
module bandpass_iir_filter_order4
  import bpiir_pkg::*;
(
  input  logic                          clk,
  input  logic                          rst,

  // coefficient write port
  input  logic                          cfg_we,
  input  logic [CFG_IDX_W-1:0]          cfg_index,
  input  logic [COEF_W-1:0]             cfg_data,

  // sample request in
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic                          chan,
  input  logic signed [SAMPLE_BITS-1:0] sample_in,
  input  logic                          block_start,

  // filtered request out
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic                          chan_out,
  output logic signed [SAMPLE_BITS-1:0] sample_out
);

  // command and status between sequencer and datapath
  bpiir_cmd_t    cmd;
  bpiir_status_t status;

  // sequencer: idle, gain product, rounding, y, then four taps overlapped
  bpiir_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .status   (status),
    .in_stall (in_stall),
    .cmd      (cmd)
  );

  // datapath: registers, delay store, multiplier, output register
  bpiir_datapath u_datapath (
    .clk         (clk),
    .rst         (rst),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .chan        (chan),
    .sample_in   (sample_in),
    .block_start (block_start),
    .cmd         (cmd),
    .status      (status),
    .out_stall   (out_stall),
    .out_valid   (out_valid),
    .chan_out    (chan_out),
    .sample_out  (sample_out)
  );

endmodule

// ----- hw/rtl/bpiir_checker.sv -----
// ----------------------------------------------------------------------------
// bpiir_checker
// port-level checks of the band-pass filter, bound to the top level
// ----------------------------------------------------------------------------
`include "bandpass_iir_filter_order4_macros.svh"

module bpiir_checker
  import bpiir_pkg::*;
(
  input logic                          clk,
  input logic                          rst,
  input logic                          in_valid,
  input logic                          in_stall,
  input logic                          out_valid,
  input logic                          out_stall,
  input logic                          chan_out,
  input logic signed [SAMPLE_BITS-1:0] sample_out
);

  // no request taken while in reset
  `BPIIR_ASSERT_ALWAYS(a_stall_in_reset, rst |-> in_stall, "input accepted during reset")

  // one sample at a time: busy right after an accepted request
  `BPIIR_ASSERT(a_busy_after_accept, (in_valid && !in_stall) |=> in_stall, "input taken while busy")

  // a result only appears at the end of a busy period
  `BPIIR_ASSERT(a_result_from_work, $rose(out_valid) |-> $past(in_stall), "result without work")

  // a stalled result holds
  `BPIIR_ASSERT(a_out_hold, (out_valid && out_stall) |=> (out_valid && $stable(sample_out) && $stable(chan_out)), "stalled result changed")

endmodule

bind bandpass_iir_filter_order4 bpiir_checker u_bpiir_checker (.*);
